// ===== rtl/core/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants of the rate monotonic scheduler.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SLOTS     = 4;   // register slots per bank
  localparam int CFG_W     = 16;  // width of a configuration register
  localparam int COUNT_W   = 16;  // width of the event counters
  localparam int IDX_W     = 2;   // width of a task index
  localparam int ADDR_W    = 5;   // byte address over eight word registers
  localparam int DATA_W    = 32;
  localparam int REG_NUM   = 2 * SLOTS;

  typedef logic [IDX_W-1:0]   task_idx_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Register bank select: index bit 2 picks the execution time bank
  typedef enum logic {
    BANK_PERIOD = 1'b0,
    BANK_EXEC   = 1'b1
  } reg_bank_t;

  // Result of the priority pick
  typedef struct packed {
    logic      found;
    task_idx_t best;
  } sel_t;

  function automatic count_t sat_add(count_t base, logic [2:0] inc);
    logic [COUNT_W:0] sum;
    sum = {1'b0, base} + (COUNT_W + 1)'(inc);
    return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rms_if.sv =====
// ----------------------------------------------------------------------------
// rms_if
// Valid/ready channels of the scheduler: tick items in, results out.
// ----------------------------------------------------------------------------
interface rms_item_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface rms_result_if import rms_pkg::*; ();
  logic          valid;
  logic          ready;
  task_idx_t     running_task;
  logic          idle;
  logic          job_finished;
  logic          preempted;
  logic [SLOTS-1:0] miss_mask;
  count_t        miss_total;
  count_t        release_total;

  modport source (output valid, output running_task, output idle, output job_finished,
                  output preempted, output miss_mask, output miss_total,
                  output release_total, input ready);
  modport sink   (input valid, input running_task, input idle, input job_finished,
                  input preempted, input miss_mask, input miss_total,
                  input release_total, output ready);
endinterface

// ===== rtl/core/rms_regs.sv =====
// ----------------------------------------------------------------------------
// rms_regs
// APB register file holding the period and execution time of each task.
// ----------------------------------------------------------------------------
module rms_regs import rms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_word_t         period [SLOTS],
  output cfg_word_t         exec_time [SLOTS]
);

  cfg_word_t  regs [REG_NUM];
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_NUM; i++) regs[i] <= '0;
    end else if (wr_en) begin
      regs[idx] <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = {{(DATA_W - CFG_W){1'b0}}, regs[idx]};

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      period[i]    = regs[{BANK_PERIOD, 2'(i)}];
      exec_time[i] = regs[{BANK_EXEC, 2'(i)}];
    end
  end

endmodule

// ===== rtl/core/rms_select.sv =====
// ----------------------------------------------------------------------------
// rms_select
// Priority pick: ready task with the shortest period, lowest index on a tie.
// ----------------------------------------------------------------------------
module rms_select import rms_pkg::*; #(
  parameter int TASKS      = 4,
  parameter int TIME_WIDTH = 16
) (
  input  logic [TIME_WIDTH-1:0] period [TASKS],
  input  logic [TASKS-1:0]      ready_mask,
  output sel_t                  sel
);

  logic [TIME_WIDTH-1:0] best_period;

  always_comb begin
    sel         = '0;
    best_period = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (ready_mask[i] && (!sel.found || period[i] < best_period)) begin
        sel.found   = 1'b1;
        sel.best    = task_idx_t'(i);
        best_period = period[i];
      end
    end
  end

endmodule

// ===== rtl/core/rms_core.sv =====
// ----------------------------------------------------------------------------
// rms_core
// Input register, per-tick scheduler step and result register.
// ----------------------------------------------------------------------------
module rms_core import rms_pkg::*; #(
  parameter int TASKS      = 4,
  parameter int TIME_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_word_t  period [SLOTS],
  input  cfg_word_t  exec_time [SLOTS],
  rms_item_if.sink   item,
  rms_result_if.source result
);

  // input register
  logic in_valid;
  logic in_tick;
  logic advance;
  logic step;

  // scheduler state
  logic [TIME_WIDTH-1:0] rem [TASKS];
  logic [TIME_WIDTH-1:0] cd [TASKS];
  task_idx_t prev_task;
  logic      prev_valid;
  count_t    miss_cnt;
  count_t    rel_cnt;

  // result register
  logic             out_valid;
  task_idx_t        out_task;
  logic             out_idle;
  logic             out_finished;
  logic             out_preempted;
  logic [SLOTS-1:0] out_miss;

  // step logic
  logic [TIME_WIDTH-1:0] p [TASKS];
  logic [TIME_WIDTH-1:0] e [TASKS];
  logic [TIME_WIDTH-1:0] rem_a [TASKS];
  logic [TIME_WIDTH-1:0] cd_a [TASKS];
  logic [TIME_WIDTH-1:0] rem_next [TASKS];
  logic [TIME_WIDTH-1:0] cd_next [TASKS];
  logic [TIME_WIDTH-1:0] rem_prev;
  logic [TIME_WIDTH-1:0] rem_best;
  logic [TASKS-1:0]      ready_mask;
  logic [SLOTS-1:0]      miss_vec;
  logic [SLOTS-1:0]      rel_vec;
  logic                  finished;
  logic                  preempt;
  count_t                miss_cnt_next;
  count_t                rel_cnt_next;
  sel_t                  sel;

  assign advance    = in_valid && (!in_tick || !out_valid || result.ready);
  assign step       = advance && in_tick;
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_tick <= item.tick;
    end
  end

  // release phase
  always_comb begin
    miss_vec = '0;
    rel_vec  = '0;
    for (int i = 0; i < TASKS; i++) begin
      p[i] = 32'(period[i]) >> 0 == 32'(period[i]) ? TIME_WIDTH'(32'(period[i]))
                                                    : '0;
      e[i] = TIME_WIDTH'(32'(exec_time[i]));
      if (p[i] == '0) begin
        rem_a[i] = '0;
        cd_a[i]  = '0;
      end else if (cd[i] == '0) begin
        rel_vec[i]  = 1'b1;
        miss_vec[i] = (rem[i] != '0);
        rem_a[i]    = e[i];
        cd_a[i]     = p[i];
      end else begin
        rem_a[i] = rem[i];
        cd_a[i]  = cd[i];
      end
      ready_mask[i] = (p[i] != '0) && (rem_a[i] != '0);
    end
  end

  rms_select #(
    .TASKS      (TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_select (
    .period     (p),
    .ready_mask (ready_mask),
    .sel        (sel)
  );

  // run phase
  always_comb begin
    rem_prev = '0;
    rem_best = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (prev_task == task_idx_t'(i)) rem_prev = rem_a[i];
      if (sel.best == task_idx_t'(i)) rem_best = rem_a[i];
    end
    preempt  = sel.found && prev_valid && (prev_task != sel.best) && (rem_prev != '0);
    finished = sel.found && (rem_best == TIME_WIDTH'(1));
    for (int i = 0; i < TASKS; i++) begin
      rem_next[i] = rem_a[i] -
                    TIME_WIDTH'(sel.found && (sel.best == task_idx_t'(i)));
      cd_next[i]  = (cd_a[i] != '0) ? cd_a[i] - TIME_WIDTH'(1) : '0;
    end
    miss_cnt_next = sat_add(miss_cnt, 3'($countones(miss_vec)));
    rel_cnt_next  = sat_add(rel_cnt, 3'($countones(rel_vec)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASKS; i++) begin
        rem[i] <= '0;
        cd[i]  <= '0;
      end
      prev_task  <= '0;
      prev_valid <= 1'b0;
      miss_cnt   <= '0;
      rel_cnt    <= '0;
    end else if (step) begin
      for (int i = 0; i < TASKS; i++) begin
        rem[i] <= rem_next[i];
        cd[i]  <= cd_next[i];
      end
      if (sel.found) prev_task <= sel.best;
      prev_valid <= sel.found && !finished;
      miss_cnt   <= miss_cnt_next;
      rel_cnt    <= rel_cnt_next;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_task      <= sel.found ? sel.best : '0;
      out_idle      <= !sel.found;
      out_finished  <= finished;
      out_preempted <= preempt;
      out_miss      <= miss_vec;
    end
  end

  assign result.valid         = out_valid;
  assign result.running_task  = out_task;
  assign result.idle          = out_idle;
  assign result.job_finished  = out_finished;
  assign result.preempted     = out_preempted;
  assign result.miss_mask     = out_miss;
  assign result.miss_total    = miss_cnt;
  assign result.release_total = rel_cnt;

endmodule

// ===== rtl/core/rate_monotonic_scheduler.sv =====
// A tick is taken into the input register; its step then writes the state and
// result registers.
// Throughput: one tick per cycle while the result sink keeps up. The step is
// a single pass from the input register through the release logic and the
// four-way priority pick into the state and result registers.
// Reset (rst, synchronous): clears registers, task state, counters, valids.
// ----------------------------------------------------------------------------
// rate_monotonic_scheduler
// Top level: APB register file and per-tick rate monotonic scheduling core.
// ----------------------------------------------------------------------------
module rate_monotonic_scheduler import rms_pkg::*; #(
  parameter int TASKS      = 4,
  parameter int TIME_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  rms_item_if.sink          item,
  rms_result_if.source      result
);

  cfg_word_t period [SLOTS];
  cfg_word_t exec_time [SLOTS];

  rms_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .period    (period),
    .exec_time (exec_time)
  );

  rms_core #(
    .TASKS      (TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .period    (period),
    .exec_time (exec_time),
    .item      (item),
    .result    (result)
  );

endmodule

// ===== rtl/core/rms_checker.sv =====
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks of the scheduler result stream.
// ----------------------------------------------------------------------------
module rms_checker import rms_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             valid,
  input logic             ready,
  input task_idx_t        running_task,
  input logic             idle,
  input logic             job_finished,
  input logic             preempted,
  input logic [SLOTS-1:0] miss_mask,
  input count_t           miss_total,
  input count_t           release_total
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  // an idle unit runs nothing, finishes nothing and preempts nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    valid && idle |-> running_task == '0 && !job_finished && !preempted)
    else $error("idle result carries run information");

  // a flagged miss is always counted
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    valid && (miss_mask != '0) |-> miss_total != '0 && release_total != '0)
    else $error("miss flagged without count");

  // counters never step back between consecutive transactions
  a_counts_monotone: assert property (@(posedge clk) disable iff (rst)
    valid && ready |=> !valid || (miss_total >= $past(miss_total) &&
                                  release_total >= $past(release_total)))
    else $error("event counter decreased");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(miss_total) && $stable(running_task))
    else $error("stalled result changed");

endmodule

bind rate_monotonic_scheduler rms_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .running_task  (result.running_task),
  .idle          (result.idle),
  .job_finished  (result.job_finished),
  .preempted     (result.preempted),
  .miss_mask     (result.miss_mask),
  .miss_total    (result.miss_total),
  .release_total (result.release_total)
);

// ===== tb/rate_monotonic_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_scheduler_tb
// Self-checking bench: drives tick transactions and APB register writes,
// predicts every per-tick schedule slot and compares the result stream.
// ----------------------------------------------------------------------------
module rate_monotonic_scheduler_tb;
  import rms_pkg::*;

  // One scheduled time slot as the result channel reports it
  typedef struct packed {
    task_idx_t        running_task;
    logic             idle;
    logic             job_finished;
    logic             preempted;
    logic [SLOTS-1:0] miss_mask;
    count_t           miss_total;
    count_t           release_total;
  } slot_t;

  class schedule_book;
    cfg_word_t period_of [SLOTS];
    cfg_word_t budget_of [SLOTS];
    cfg_word_t work_left [SLOTS];
    cfg_word_t countdown [SLOTS];
    task_idx_t last_task;
    bit        last_busy;
    count_t    misses;
    count_t    releases;
    slot_t     slot_queue[$];
    int        mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        period_of[i] = '0;
        budget_of[i] = '0;
        work_left[i] = '0;
        countdown[i] = '0;
      end
      last_task  = '0;
      last_busy  = 1'b0;
      misses     = '0;
      releases   = '0;
      mismatches = 0;
    endfunction

    function count_t bump(count_t c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void set_reg(reg_bank_t bank, task_idx_t t, cfg_word_t v);
      if (bank == BANK_PERIOD) begin
        period_of[t] = v;
      end else begin
        budget_of[t] = v;
      end
    endfunction

    // Advance one time unit on a tick item and queue the slot it produces
    function void accept_tick(logic t);
      slot_t     want;
      bit        found;
      task_idx_t pick;
      cfg_word_t best_period;
      if (!t) return;
      want        = '0;
      found       = 1'b0;
      pick        = '0;
      best_period = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (period_of[i] == 0) begin
          work_left[i] = '0;
          countdown[i] = '0;
        end else if (countdown[i] == 0) begin
          if (work_left[i] != 0) begin
            want.miss_mask[i] = 1'b1;
            misses = bump(misses);
          end
          work_left[i] = budget_of[i];
          countdown[i] = period_of[i];
          releases = bump(releases);
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (period_of[i] != 0 && work_left[i] != 0 &&
            (!found || period_of[i] < best_period)) begin
          found       = 1'b1;
          pick        = task_idx_t'(i);
          best_period = period_of[i];
        end
      end
      if (found) begin
        want.preempted    = last_busy && last_task != pick && work_left[last_task] != 0;
        work_left[pick]   = work_left[pick] - 1'b1;
        want.job_finished = (work_left[pick] == 0);
        want.running_task = pick;
        last_task         = pick;
        last_busy         = !want.job_finished;
      end else begin
        want.idle = 1'b1;
        last_busy = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (countdown[i] != 0) countdown[i] = countdown[i] - 1'b1;
      end
      want.miss_total    = misses;
      want.release_total = releases;
      slot_queue.push_back(want);
    endfunction

    task flag_mismatch(string what);
      if (mismatches < 100) $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_slot(slot_t got);
      slot_t want;
      if (slot_queue.size() == 0) begin
        flag_mismatch("result with no tick pending");
        return;
      end
      want = slot_queue.pop_front();
      if (got.running_task !== want.running_task)
        flag_mismatch($sformatf("running_task %0d, want %0d",
                                got.running_task, want.running_task));
      if (got.idle !== want.idle)
        flag_mismatch($sformatf("idle %b, want %b", got.idle, want.idle));
      if (got.job_finished !== want.job_finished)
        flag_mismatch($sformatf("job_finished %b, want %b",
                                got.job_finished, want.job_finished));
      if (got.preempted !== want.preempted)
        flag_mismatch($sformatf("preempted %b, want %b", got.preempted, want.preempted));
      if (got.miss_mask !== want.miss_mask)
        flag_mismatch($sformatf("miss_mask %b, want %b", got.miss_mask, want.miss_mask));
      if (got.miss_total !== want.miss_total)
        flag_mismatch($sformatf("miss_total %0d, want %0d",
                                got.miss_total, want.miss_total));
      if (got.release_total !== want.release_total)
        flag_mismatch($sformatf("release_total %0d, want %0d",
                                got.release_total, want.release_total));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rms_item_if   item_ch ();
  rms_result_if result_ch ();

  schedule_book book = new();
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  rate_monotonic_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[rate_monotonic_scheduler] ERROR");
    $finish;
  end

  // Result side: check every accepted transaction, then pick the next ready
  initial begin
    slot_t got;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.running_task  = result_ch.running_task;
        got.idle          = result_ch.idle;
        got.job_finished  = result_ch.job_finished;
        got.preempted     = result_ch.preempted;
        got.miss_mask     = result_ch.miss_mask;
        got.miss_total    = result_ch.miss_total;
        got.release_total = result_ch.release_total;
        book.check_slot(got);
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Setup phase leaves psel high; the caller drops it after the last write
  task automatic apb_write(input reg_bank_t bank, input task_idx_t t, input cfg_word_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bank, t, 2'b00};
    pwdata  <= {{(DATA_W - CFG_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(bank, t, v);
  endtask

  task automatic load_tasks(input cfg_word_t periods [SLOTS], input cfg_word_t budgets [SLOTS]);
    for (int i = 0; i < SLOTS; i++) begin
      apb_write(BANK_PERIOD, task_idx_t'(i), periods[i]);
      apb_write(BANK_EXEC, task_idx_t'(i), budgets[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input logic t);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.tick  <= t;
    do @(posedge clk); while (!item_ch.ready);
    book.accept_tick(t);
  endtask

  // Wait out all pending slots, then the pipeline depth for a trailing hold
  task automatic drain();
    item_ch.valid <= 1'b0;
    for (int n = 0; n < 20000 && book.slot_queue.size() != 0; n++) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic cfg_word_t random_period();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 14) return '1;
    if (r < 20) return cfg_word_t'($urandom_range(65535));
    if (r < 30) return cfg_word_t'(1);
    return cfg_word_t'($urandom_range(2, 12));
  endfunction

  function automatic cfg_word_t random_budget();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 18) return '1;
    if (r < 24) return cfg_word_t'($urandom_range(65535));
    return cfg_word_t'($urandom_range(1, 5));
  endfunction

  initial begin
    cfg_word_t periods [SLOTS];
    cfg_word_t budgets [SLOTS];
    int        ticks;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    item_ch.valid = 1'b0;
    item_ch.tick  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 63;

    // Zero budget, a long background job, a disabled task with a budget
    periods = '{16'd1, 16'd4, 16'hFFFF, 16'd0};
    budgets = '{16'd0, 16'd2, 16'hFFFF, 16'd7};
    load_tasks(periods, budgets);
    send_tick(1'b0);
    for (int i = 0; i < 8; i++) send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Overrun and tie on period, drop the background job, enable the shortest
    periods = '{16'd2, 16'd2, 16'd0, 16'd1};
    budgets = '{16'd3, 16'd1, 16'd0, 16'd1};
    load_tasks(periods, budgets);
    for (int i = 0; i < 8; i++) send_tick(1'b1);
    drain();

    // Everything disabled: idle slots
    periods = '{16'd0, 16'd0, 16'd0, 16'd0};
    load_tasks(periods, budgets);
    for (int i = 0; i < 3; i++) send_tick(1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p == 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (p == 4) begin
          periods[i] = '1;
          budgets[i] = '1;
        end else if (p == 7) begin
          periods[i] = cfg_word_t'(1);
          budgets[i] = cfg_word_t'(1);
        end else begin
          periods[i] = random_period();
          budgets[i] = random_budget();
        end
      end
      load_tasks(periods, budgets);
      ticks = 0;
      while (ticks < 100) begin
        if ($urandom_range(7) == 0) begin
          send_tick(1'b0);
        end else begin
          send_tick(1'b1);
          ticks++;
        end
      end
      drain();
    end

    if (book.slot_queue.size() != 0)
      book.flag_mismatch($sformatf("%0d slots never reported", book.slot_queue.size()));
    if (book.mismatches == 0) begin
      $display("[rate_monotonic_scheduler] OK");
    end else begin
      $display("[rate_monotonic_scheduler] ERROR");
    end
    $finish;
  end

endmodule
